[hw/rtl/lphs_pkg.sv]
// Shared widths, codes and command/status bundles for the linear probe hash set.
`timescale 1ns / 1ps
package lphs_pkg;

    localparam int DEF_SLOTS = 16;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 8;
    localparam int HOME_W   = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int TAG_W    = 2;

    // request commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // slot tags
    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write one empty slot of the clearing pass
        logic load;    // take a request, read its home slot
        logic step;    // advance the probe one slot
        logic finish;  // resolve the probe, update the table, emit result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;  // clearing pass is at the last slot
        logic stop;      // probe ends at the slot now held
    } t_dp_sts;

endpackage

[hw/rtl/linear_probe_hash_set.sv]
// Top level of the linear probe hash set: controller plus datapath.
`timescale 1ns / 1ps
// Hash set of byte keys, open addressing with linear probing and tombstones.
// Request channel: i_cmd (0 insert, 1 delete, 2 lookup), i_key, i_home_slot.
//   A beat is taken at a rising edge with start high and busy low.
// Result channel: o_status, o_found, o_slot, marked by o_valid for exactly
//   one cycle; the receiver cannot hold it off, so nothing ever stalls here.
// Probe walk: a request probes k slots (1..SLOTS); the result beat is
//   taken at the edge after the one that raises o_valid, and busy drops
//   at the same edge that raises o_valid.
//   One slot is examined per cycle through the single-port slot memory
//   (registered read); a request is taken only once the last has finished.
// Reset (i_rst_n low, synchronous): the controller runs a clearing pass
//   that marks every slot empty, one slot a cycle;
//   busy is high throughout and no request is taken.
// Insert of a new key reuses the first tombstone passed, else the empty slot
//   that ended the probe, else reports a full table. Delete leaves a tombstone.
// o_slot carries the low 4 bits of the slot index, 0 when there is none.
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HOME_W-1:0]   i_home_slot,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [SLOT_W-1:0]   o_slot
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lphs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    lphs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_req_cmd   (i_cmd),
        .i_key       (i_key),
        .i_home_slot (i_home_slot),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_slot      (o_slot)
    );

endmodule

[hw/rtl/lphs_ctrl.sv]
// Controller state machine: clearing pass, idle, probe walk.
`timescale 1ns / 1ps
module lphs_ctrl
    import lphs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.stop) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[hw/rtl/lphs_dp.sv]
// Datapath: slot memory, probe pointer and counter, result registers.
`timescale 1ns / 1ps
module lphs_dp
    import lphs_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [CMD_W-1:0]    i_req_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HOME_W-1:0]   i_home_slot,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [SLOT_W-1:0]   o_slot
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int VW    = (CNT_W > HOME_W) ? CNT_W : HOME_W;
    localparam int ENT_W = TAG_W + KEY_W;

    // slot memory: {tag, key}
    logic [ENT_W-1:0] r_mem [SLOTS];

    logic [ENT_W-1:0] r_rd;
    logic [IDX_W-1:0] r_cur;
    logic [CNT_W-1:0] r_cnt;
    logic             r_tomb_vld;
    logic [IDX_W-1:0] r_tomb;
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic                r_found;
    logic [SLOT_W-1:0]   r_slot;

    logic [VW-1:0]     home_mod;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [TAG_W-1:0]  cur_tag;
    logic [KEY_W-1:0]  cur_key;
    logic              is_empty;
    logic              is_tomb;
    logic              is_hit;
    logic              tomb_any;
    logic [IDX_W-1:0]  tomb_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [STATUS_W-1:0] n_status;
    logic                n_found;
    logic [IDX_W-1:0]    n_slot_idx;

    // home slot modulo SLOTS by up to 8 subtracts (home is only 4 bits); exact for SLOTS >= 2
    always_comb begin
        home_mod = VW'(i_home_slot);
        for (int k = 0; k < 8; k++) begin
            if (home_mod >= VW'(SLOTS)) begin
                home_mod = home_mod - VW'(SLOTS);
            end
        end
    end
    assign start_idx = IDX_W'(home_mod);

    assign next_idx = (r_cur == IDX_W'(SLOTS - 1)) ? '0 : r_cur + 1'b1;
    assign rd_addr  = i_cmd.load ? start_idx : next_idx;
    assign rd_en    = i_cmd.load | i_cmd.step;

    assign cur_tag  = r_rd[ENT_W-1 -: TAG_W];
    assign cur_key  = r_rd[KEY_W-1:0];
    assign is_empty = (cur_tag == TAG_EMPTY);
    assign is_tomb  = (cur_tag == TAG_TOMB);
    assign is_hit   = !is_empty && !is_tomb && (cur_key == r_key);

    assign tomb_any = r_tomb_vld | is_tomb;
    assign tomb_idx = r_tomb_vld ? r_tomb : r_cur;

    assign o_sts.stop     = is_hit | is_empty | (r_cnt == CNT_W'(SLOTS));
    assign o_sts.clr_last = (r_cur == IDX_W'(SLOTS - 1));

    // resolve the probe
    always_comb begin
        n_status   = ST_NOTFOUND;
        n_found    = 1'b0;
        n_slot_idx = '0;
        wr_en      = 1'b0;
        wr_addr    = r_cur;
        wr_data    = {TAG_EMPTY, {KEY_W{1'b0}}};
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish) begin
            case (r_cmd)
                CMD_INSERT: begin
                    if (is_hit) begin
                        n_status   = ST_PRESENT;
                        n_found    = 1'b1;
                        n_slot_idx = r_cur;
                    end else if (tomb_any || is_empty) begin
                        wr_en      = 1'b1;
                        wr_addr    = tomb_any ? tomb_idx : r_cur;
                        wr_data    = {TAG_USED, r_key};
                        n_status   = ST_DONE;
                        n_slot_idx = wr_addr;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                CMD_DELETE: begin
                    if (is_hit) begin
                        wr_en      = 1'b1;
                        wr_data    = {TAG_TOMB, r_key};
                        n_status   = ST_DONE;
                        n_found    = 1'b1;
                        n_slot_idx = r_cur;
                    end
                end
                CMD_LOOKUP: begin
                    if (is_hit) begin
                        n_status   = ST_DONE;
                        n_found    = 1'b1;
                        n_slot_idx = r_cur;
                    end
                end
                default: begin
                    n_status = ST_NOTFOUND;
                end
            endcase
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // probe control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_cnt      <= '0;
            r_tomb_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_cur <= next_idx;
            end else if (i_cmd.load) begin
                r_cur      <= start_idx;
                r_cnt      <= CNT_W'(1);
                r_tomb_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_cur <= next_idx;
                r_cnt <= r_cnt + 1'b1;
                if (is_tomb && !r_tomb_vld) begin
                    r_tomb_vld <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd;
            r_key <= i_key;
        end
        if (i_cmd.step && is_tomb && !r_tomb_vld) begin
            r_tomb <= r_cur;
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_slot   <= SLOT_W'(n_slot_idx);
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_slot   = r_slot;

endmodule
